### hdl/lmacc_pkg.sv
`timescale 1ns / 1ps
// Shared types for the Legendre multipole accumulator.
// Controller states and the command/status records between controller and datapath.
package lmacc_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_MSTART,
		S_MSTEP,
		S_MSTORE,
		S_POLY,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV,
		OP_MSTART,
		OP_MSTEP,
		OP_MSTORE,
		OP_POLY,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] sel;
		logic [9:0] grp_idx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic cnt_nz;
	} status_t;

	localparam int unsigned IN_W  = 120;
	localparam int unsigned OUT_W = 336;
	localparam int unsigned CFG_W = 11;

	localparam logic REG_LIN = 1'b0;
	localparam logic REG_GRP = 1'b1;

endpackage

### hdl/lmacc_dp.sv
`timescale 1ns / 1ps
// Datapath: restoring divider, shared radix-16 multiplier, polynomial step,
// saturating accumulators and output register. Depends on lmacc_pkg.
module lmacc_dp
	import lmacc_pkg::*;
#(
	parameter int unsigned F = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  in_data,
	output status_t          status,
	output logic [OUT_W-1:0] out_data,
	output logic             out_last
);

	localparam int unsigned UW = F + 1;
	localparam logic signed [63:0] ONE = 64'sd1 <<< F;
	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	logic [39:0]       w_q;
	logic [40:0]       rem_q;
	logic [UW-1:0]     u_q;
	logic              div_run_q;
	logic              cnt_nz_q;
	logic [63:0]       p2_q, p4_q, p6_q, p8_q;
	logic [63:0]       tmag_q [4];
	logic              tneg_q [4];
	logic [127:0]      a_sh_q, prod_q;
	logic [63:0]       b_sh_q;
	logic signed [63:0] acc_q [5];
	logic signed [63:0] osum_q [5];
	logic [9:0]        oidx_q;
	logic              olast_q;

	logic [40:0]       mu_raw, mag, rem2;
	logic              ge;
	logic [63:0]       a_sel, b_sel, res;
	logic [127:0]      rsum;
	logic signed [63:0] q, t, v;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
	                                                input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(ACC_MAX))
			return ACC_MAX;
		if (s < -65'(ACC_MAX))
			return -ACC_MAX;
		return s[63:0];
	endfunction

	assign mu_raw = in_data[112:72];
	assign mag    = mu_raw[40] ? (~mu_raw + 41'd1) : mu_raw;
	assign rem2   = {rem_q[39:0], 1'b0};
	assign ge     = rem2 >= {1'b0, w_q};

	always_comb begin
		case (cmd.sel)
			3'd0: begin a_sel = 64'(u_q); b_sel = 64'(u_q); end
			3'd1: begin a_sel = p2_q; b_sel = p2_q; end
			3'd2: begin a_sel = p4_q; b_sel = p2_q; end
			3'd3: begin a_sel = p4_q; b_sel = p4_q; end
			default: begin a_sel = 64'(w_q); b_sel = tmag_q[cmd.sel[1:0]]; end
		endcase
	end

	// round half up, then shift by F plus the order scale
	always_comb begin
		case (cmd.sel)
			3'd4: begin
				rsum = prod_q + (128'd1 << (F));
				res  = 64'(rsum >> (F + 1));
			end
			3'd5: begin
				rsum = prod_q + (128'd1 << (F + 2));
				res  = 64'(rsum >> (F + 3));
			end
			3'd6: begin
				rsum = prod_q + (128'd1 << (F + 3));
				res  = 64'(rsum >> (F + 4));
			end
			3'd7: begin
				rsum = prod_q + (128'd1 << (F + 6));
				res  = 64'(rsum >> (F + 7));
			end
			default: begin
				rsum = prod_q + (128'd1 << (F - 1));
				res  = 64'(rsum >> F);
			end
		endcase
		v = tneg_q[cmd.sel[1:0]] ? -$signed(res) : $signed(res);
	end

	always_comb begin
		case (cmd.sel[1:0])
			2'd0: begin
				q = 64'sd3 * $signed(p2_q) - ONE;
				t = 64'sd5 * q;
			end
			2'd1: begin
				q = 64'sd35 * $signed(p4_q) - 64'sd30 * $signed(p2_q) + 64'sd3 * ONE;
				t = 64'sd9 * q;
			end
			2'd2: begin
				q = 64'sd231 * $signed(p6_q) - 64'sd315 * $signed(p4_q)
					+ 64'sd105 * $signed(p2_q) - 64'sd5 * ONE;
				t = 64'sd13 * q;
			end
			default: begin
				q = 64'sd6435 * $signed(p8_q) - 64'sd12012 * $signed(p6_q)
					+ 64'sd6930 * $signed(p4_q) - 64'sd1260 * $signed(p2_q) + 64'sd35 * ONE;
				t = 64'sd17 * q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++)
				acc_q[i] <= '0;
		end else begin
			if (cmd.op == OP_MSTORE && cmd.sel[2]) begin
				acc_q[cmd.sel[1:0] + 3'd1] <= sat_add(acc_q[cmd.sel[1:0] + 3'd1], v);
				if (cmd.sel == 3'd4)
					acc_q[0] <= sat_add(acc_q[0], $signed(64'(w_q)));
			end else if (cmd.op == OP_EMIT) begin
				for (int i = 0; i < 5; i++)
					acc_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				w_q      <= in_data[71:32];
				cnt_nz_q <= |in_data[31:0];
				rem_q    <= mag;
				if (in_data[71:32] == 40'd0) begin
					u_q       <= '0;
					div_run_q <= 1'b0;
				end else if (mag >= {1'b0, in_data[71:32]}) begin
					u_q       <= UW'(1) << F;
					div_run_q <= 1'b0;
				end else begin
					u_q       <= '0;
					div_run_q <= 1'b1;
				end
			end
			OP_DIV: begin
				if (div_run_q) begin
					rem_q <= ge ? (rem2 - {1'b0, w_q}) : rem2;
					u_q   <= {u_q[UW-2:0], ge};
				end
			end
			OP_MSTART: begin
				a_sh_q <= {64'd0, a_sel};
				b_sh_q <= b_sel;
				prod_q <= '0;
			end
			OP_MSTEP: begin
				prod_q <= prod_q + a_sh_q * b_sh_q[3:0];
				a_sh_q <= a_sh_q << 4;
				b_sh_q <= b_sh_q >> 4;
			end
			OP_MSTORE: begin
				case (cmd.sel)
					3'd0: p2_q <= res;
					3'd1: p4_q <= res;
					3'd2: p6_q <= res;
					3'd3: p8_q <= res;
					default: ;
				endcase
			end
			OP_POLY: begin
				tneg_q[cmd.sel[1:0]] <= t[63];
				tmag_q[cmd.sel[1:0]] <= t[63] ? 64'(-t) : 64'(t);
			end
			OP_EMIT: begin
				for (int i = 0; i < 5; i++)
					osum_q[i] <= acc_q[i];
				oidx_q  <= cmd.grp_idx;
				olast_q <= cmd.last;
			end
			default: ;
		endcase
	end

	assign status.cnt_nz = cnt_nz_q;
	assign out_data = {6'd0, oidx_q, osum_q[4], osum_q[3], osum_q[2], osum_q[1], osum_q[0]};
	assign out_last = olast_q;

endmodule

### hdl/lmacc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequencing FSM, bin/group position counters, config registers,
// output valid flag. Depends on lmacc_pkg.
module lmacc_ctrl
	import lmacc_pkg::*;
#(
	parameter int unsigned F = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CFG_W-1:0] wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  status_t          status,
	output cmd_t             cmd
);

	localparam int unsigned SW = $clog2(((F > 16) ? F : 16) + 1);
	localparam logic [SW-1:0] DIV_LAST = SW'(F - 1);
	localparam logic [SW-1:0] MUL_LAST = SW'(15);

	state_t       state_q, state_d;
	logic [SW-1:0] step_q;
	logic [2:0]   job_q;
	logic [9:0]   lin_pos_q, grp_pos_q;
	logic [10:0]  lin_cfg_q, grp_cfg_q, lin_n, grp_n;
	logic         out_valid_q;
	logic         grp_end, last, can_emit, emit, in_fire;

	function automatic logic [10:0] clamp(input logic [10:0] x);
		if (x == 11'd0)
			return 11'd1;
		if (x > 11'd1024)
			return 11'd1024;
		return x;
	endfunction

	assign lin_n    = clamp(lin_cfg_q);
	assign grp_n    = clamp(grp_cfg_q);
	assign grp_end  = (11'(lin_pos_q) + 11'd1) >= lin_n;
	assign last     = (11'(grp_pos_q) + 11'd1) >= grp_n;
	assign can_emit = !out_valid_q || out_ready;
	assign emit     = (state_q == S_FIN) && grp_end && can_emit;
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_fire) state_d = S_CHECK;
			S_CHECK:  state_d = status.cnt_nz ? S_DIV : S_FIN;
			S_DIV:    if (step_q == DIV_LAST) state_d = S_MSTART;
			S_MSTART: state_d = S_MSTEP;
			S_MSTEP:  if (step_q == MUL_LAST) state_d = S_MSTORE;
			S_MSTORE: begin
				if (job_q == 3'd3)
					state_d = S_POLY;
				else if (job_q == 3'd7)
					state_d = S_FIN;
				else
					state_d = S_MSTART;
			end
			S_POLY:   if (step_q[1:0] == 2'd3) state_d = S_MSTART;
			S_FIN:    if (!grp_end || can_emit) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = OP_NOP;
		cmd.sel     = job_q;
		cmd.grp_idx = grp_pos_q;
		cmd.last    = last;
		unique case (state_q)
			S_IDLE:   if (in_fire) cmd.op = OP_LOAD;
			S_DIV:    cmd.op = OP_DIV;
			S_MSTART: cmd.op = OP_MSTART;
			S_MSTEP:  cmd.op = OP_MSTEP;
			S_MSTORE: cmd.op = OP_MSTORE;
			S_POLY: begin
				cmd.op  = OP_POLY;
				cmd.sel = {1'b0, step_q[1:0]};
			end
			S_FIN:    if (emit) cmd.op = OP_EMIT;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			job_q       <= '0;
			lin_pos_q   <= '0;
			grp_pos_q   <= '0;
			lin_cfg_q   <= 11'd1;
			grp_cfg_q   <= 11'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_index)
					REG_LIN: lin_cfg_q <= wr_data;
					REG_GRP: grp_cfg_q <= wr_data;
					default: ;
				endcase
			end
			if (state_d != state_q)
				step_q <= '0;
			else
				step_q <= step_q + SW'(1);
			if (state_q == S_CHECK)
				job_q <= '0;
			else if (state_q == S_MSTORE)
				job_q <= job_q + 3'd1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (state_q == S_FIN) begin
				if (!grp_end) begin
					lin_pos_q <= lin_pos_q + 10'd1;
				end else if (can_emit) begin
					lin_pos_q <= '0;
					grp_pos_q <= last ? 10'd0 : grp_pos_q + 10'd1;
				end
			end
		end
	end

endmodule

### hdl/legendre_multipole_accumulator_top.sv
`timescale 1ns / 1ps
// Legendre multipole accumulator, even orders 0..8.
// A bin with nonzero count holds the block from acceptance to the next acceptance (serial
// divider, then eight 16-step radix-16 multiplications on one shared multiplier); a zero-count
// bin skips both. One bin in flight; a finished group waits in the output register and stalls
// the next one. Reset (arst_n low, asynchronous) clears accumulators, positions, config to 1.
module legendre_multipole_accumulator_top
	import lmacc_pkg::*;
#(
	parameter int unsigned RATIO_FRACTION_BITS = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CFG_W-1:0] wr_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// pair_count[31:0], weight_sum[71:32], mu_sum[112:72], zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// order0_sum, order2_sum, order4_sum, order6_sum, order8_sum, group_index, zero pad
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast
);

	cmd_t    cmd;
	status_t status;

	lmacc_ctrl #(.F(RATIO_FRACTION_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lmacc_dp #(.F(RATIO_FRACTION_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.status   (status),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule
